// ===== sv/fpfc_pkg.sv =====
package fpfc_pkg;

  // Default counter width; screen and source dimensions are clamped to 1 .. 2**DIM_BITS.
  localparam int DIM_BITS_DEFAULT = 12;

  localparam int PIX_W  = 16;
  localparam int ADDR_W = 27;
  localparam int DIMR_W = 13;
  localparam int PITCH_W = 15;
  localparam int LAYOUT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT        = 3'd5;

  localparam logic [DIMR_W-1:0]   SCREEN_WIDTH_RST  = 13'd320;
  localparam logic [DIMR_W-1:0]   SCREEN_HEIGHT_RST = 13'd256;
  localparam logic [DIMR_W-1:0]   SOURCE_WIDTH_RST  = 13'd320;
  localparam logic [DIMR_W-1:0]   SOURCE_HEIGHT_RST = 13'd256;
  localparam logic [PITCH_W-1:0]  ROW_PITCH_RST     = 15'd640;

  // The layout code splits into three independent controls.
  typedef struct packed {
    logic is555;
    logic bgr;
    logic swap;
  } layout_t;

  localparam layout_t LAYOUT_RST = '{is555: 1'b0, bgr: 1'b0, swap: 1'b0};

  localparam layout_t LAYOUT_RGB565      = '{is555: 1'b0, bgr: 1'b0, swap: 1'b0};
  localparam layout_t LAYOUT_RGB565_SWAP = '{is555: 1'b0, bgr: 1'b0, swap: 1'b1};
  localparam layout_t LAYOUT_BGR565      = '{is555: 1'b0, bgr: 1'b1, swap: 1'b0};
  localparam layout_t LAYOUT_BGR565_SWAP = '{is555: 1'b0, bgr: 1'b1, swap: 1'b1};
  localparam layout_t LAYOUT_RGB555      = '{is555: 1'b1, bgr: 1'b0, swap: 1'b0};
  localparam layout_t LAYOUT_RGB555_SWAP = '{is555: 1'b1, bgr: 1'b0, swap: 1'b1};
  localparam layout_t LAYOUT_BGR555      = '{is555: 1'b1, bgr: 1'b1, swap: 1'b0};
  localparam layout_t LAYOUT_BGR555_SWAP = '{is555: 1'b1, bgr: 1'b1, swap: 1'b1};

endpackage

// ===== sv/fpfc_pixel_conv.sv =====
module fpfc_pixel_conv (
  input  logic [fpfc_pkg::PIX_W-1:0] src_pixel,
  input  fpfc_pkg::layout_t          layout,
  output logic [fpfc_pkg::PIX_W-1:0] dst_pixel
);

  logic [4:0] red;
  logic [5:0] green;
  logic [4:0] blue;
  logic [4:0] lo_ch;
  logic [4:0] hi_ch;
  logic [fpfc_pkg::PIX_W-1:0] packed_px;

  assign red   = src_pixel[15:11];
  assign green = src_pixel[10:5];
  assign blue  = src_pixel[4:0];

  assign hi_ch = layout.bgr ? blue : red;
  assign lo_ch = layout.bgr ? red : blue;

  // The 555 layouts drop the least significant green bit and leave bit 15 clear.
  always_comb begin
    if (layout.is555) begin
      packed_px = {1'b0, hi_ch, green[5:1], lo_ch};
    end else begin
      packed_px = {hi_ch, green, lo_ch};
    end
  end

  assign dst_pixel = layout.swap ? {packed_px[7:0], packed_px[15:8]} : packed_px;

endmodule

// ===== sv/framebuffer_present_format_converter.sv =====
// Channel  Direction  Ports                                            Handshake
// in       input      in_source_pixel                                  in_valid / in_stall
// out      output     out_dest_address, out_dest_pixel, out_frame_last out_valid / out_stall
// cfg      input      cfg_index, cfg_wdata                             cfg_we, no wait
//
// One pixel is accepted per clock while in_stall is low; a write passes through the input stage
// (geometry and counters) and then the output stage (pitch multiply) before it is on the outputs.
// Pixels outside the copy area are dropped in the input stage and never occupy the output.
// rst_n is synchronous and active low; it clears the counters, valids and configuration registers.
// in_stall rises only when both stages hold words and out_stall is high.
module framebuffer_present_format_converter #(
  parameter int DIM_BITS = fpfc_pkg::DIM_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fpfc_pkg::PIX_W-1:0]       in_source_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fpfc_pkg::ADDR_W-1:0]      out_dest_address,
  output logic [fpfc_pkg::PIX_W-1:0]       out_dest_pixel,
  output logic                             out_frame_last,
  input  logic                             cfg_we,
  input  logic [fpfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DW = DIM_BITS + 1;
  localparam int VW = (DW > fpfc_pkg::DIMR_W) ? DW : fpfc_pkg::DIMR_W;
  localparam logic [VW-1:0] DIM_TOP = VW'(1) << DIM_BITS;
  localparam int PW = DIM_BITS + fpfc_pkg::PITCH_W;

  function automatic logic [DW-1:0] clamp_dim(input logic [fpfc_pkg::DIMR_W-1:0] v);
    logic [VW-1:0] ve;
    ve = VW'(v);
    if (v == '0) begin
      return DW'(1);
    end else if (ve > DIM_TOP) begin
      return DW'(DIM_TOP);
    end else begin
      return DW'(ve);
    end
  endfunction

  // Configuration registers.
  logic [fpfc_pkg::DIMR_W-1:0]  screen_width_r, screen_height_r;
  logic [fpfc_pkg::DIMR_W-1:0]  source_width_r, source_height_r;
  logic [fpfc_pkg::PITCH_W-1:0] row_pitch_r;
  fpfc_pkg::layout_t            layout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= fpfc_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= fpfc_pkg::SCREEN_HEIGHT_RST;
      source_width_r  <= fpfc_pkg::SOURCE_WIDTH_RST;
      source_height_r <= fpfc_pkg::SOURCE_HEIGHT_RST;
      row_pitch_r     <= fpfc_pkg::ROW_PITCH_RST;
      layout_r        <= fpfc_pkg::LAYOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpfc_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[fpfc_pkg::DIMR_W-1:0];
        fpfc_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[fpfc_pkg::DIMR_W-1:0];
        fpfc_pkg::REG_SOURCE_WIDTH:  source_width_r  <= cfg_wdata[fpfc_pkg::DIMR_W-1:0];
        fpfc_pkg::REG_SOURCE_HEIGHT: source_height_r <= cfg_wdata[fpfc_pkg::DIMR_W-1:0];
        fpfc_pkg::REG_ROW_PITCH:     row_pitch_r     <= cfg_wdata;
        fpfc_pkg::REG_LAYOUT:        layout_r        <= fpfc_pkg::layout_t'(cfg_wdata[2:0]);
        default: ;
      endcase
    end
  end

  // Copy area geometry.
  logic [DW-1:0]       scr_w, scr_h, src_w, src_h, copy_w, copy_h;
  logic [DW-1:0]       off_x_full, off_y_full;
  logic [DIM_BITS-1:0] off_x, off_y;

  assign scr_w  = clamp_dim(screen_width_r);
  assign scr_h  = clamp_dim(screen_height_r);
  assign src_w  = clamp_dim(source_width_r);
  assign src_h  = clamp_dim(source_height_r);
  assign copy_w = (src_w < scr_w) ? src_w : scr_w;
  assign copy_h = (src_h < scr_h) ? src_h : scr_h;
  assign off_x_full = (scr_w - copy_w) >> 1;
  assign off_y_full = (scr_h - copy_h) >> 1;
  assign off_x = off_x_full[DIM_BITS-1:0];
  assign off_y = off_y_full[DIM_BITS-1:0];

  // Handshake between the two stages.
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s2_take, s1_take, in_acc;

  assign s2_take  = !out_valid_r || !out_stall;
  assign s1_take  = !s1_valid_r || s2_take;
  assign in_stall = !s1_take;
  assign in_acc   = in_valid && s1_take;

  // Position counters.
  logic [DIM_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DW-1:0]       col_e, row_e, col_inc, row_inc;

  assign col_e   = DW'(col_r);
  assign row_e   = DW'(row_r);
  assign col_inc = col_e + DW'(1);
  assign row_inc = row_e + DW'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_inc >= src_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= src_h) ? '0 : row_inc[DIM_BITS-1:0];
      end else begin
        col_nxt = col_inc[DIM_BITS-1:0];
      end
    end
  end

  // Input stage: area test, flipped row and screen column.
  logic                      s1_area_r, s1_area_nxt;
  logic                      s1_last_r, s1_last_nxt;
  logic [DIM_BITS-1:0]       s1_y_r, s1_y_nxt;
  logic [DIM_BITS-1:0]       s1_x_r, s1_x_nxt;
  logic [fpfc_pkg::PIX_W-1:0] s1_pix_r;
  logic [DW-1:0]             y_full;

  assign y_full       = DW'(off_y) + (copy_h - DW'(1) - row_e);
  assign s1_y_nxt     = y_full[DIM_BITS-1:0];
  assign s1_x_nxt     = off_x + col_r;
  assign s1_area_nxt  = (col_e < copy_w) && (row_e < copy_h);
  assign s1_last_nxt  = (col_e == copy_w - DW'(1)) && (row_e == copy_h - DW'(1));
  assign s1_valid_nxt = in_acc ? 1'b1 : (s2_take ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_area_r <= s1_area_nxt;
      s1_last_r <= s1_last_nxt;
      s1_y_r    <= s1_y_nxt;
      s1_x_r    <= s1_x_nxt;
      s1_pix_r  <= in_source_pixel;
    end
  end

  // Output stage: byte address and pixel conversion.
  logic [PW-1:0]                 row_bytes;
  logic [fpfc_pkg::ADDR_W-1:0]   addr_nxt, out_addr_r;
  logic [fpfc_pkg::PIX_W-1:0]    pix_nxt, out_pix_r;
  logic                          out_last_r;

  assign row_bytes = s1_y_r * row_pitch_r;
  assign addr_nxt  = fpfc_pkg::ADDR_W'(row_bytes) + fpfc_pkg::ADDR_W'({s1_x_r, 1'b0});

  fpfc_pixel_conv u_conv (
    .src_pixel (s1_pix_r),
    .layout    (layout_r),
    .dst_pixel (pix_nxt)
  );

  assign out_valid_nxt = s2_take ? (s1_valid_r && s1_area_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      out_addr_r <= addr_nxt;
      out_pix_r  <= pix_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_address = out_addr_r;
  assign out_dest_pixel   = out_pix_r;
  assign out_frame_last   = out_last_r;

endmodule

// ===== test/framebuffer_present_format_converter_test.sv =====
`timescale 1ns / 1ps

module framebuffer_present_format_converter_test;

  localparam int DIM_LIMIT = 1 << fpfc_pkg::DIM_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_PIXELS = 50;
  localparam int RANDOM_PHASES = 12;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [fpfc_pkg::ADDR_W-1:0] addr;
    logic [fpfc_pkg::PIX_W-1:0]  pixel;
    logic                        last;
  } pixel_write_t;

  typedef enum logic [1:0] {ROW_REG, ROW_PIXEL, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [fpfc_pkg::CFG_IDX_W-1:0]  index;
    logic [fpfc_pkg::CFG_DATA_W-1:0] value;
    logic [fpfc_pkg::PIX_W-1:0]      pixel;
    pixel_write_t                    known;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [fpfc_pkg::PIX_W-1:0] in_source_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [fpfc_pkg::ADDR_W-1:0] out_dest_address;
  logic [fpfc_pkg::PIX_W-1:0] out_dest_pixel;
  logic out_frame_last;
  logic cfg_we = 1'b0;
  logic [fpfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fpfc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Geometry and layout as the block should currently see them.
  logic [fpfc_pkg::DIMR_W-1:0] scr_w_q, scr_h_q, src_w_q, src_h_q;
  logic [fpfc_pkg::PITCH_W-1:0] pitch_q;
  fpfc_pkg::layout_t layout_q;
  int unsigned col_q, row_q;

  pixel_write_t pending_writes[$];
  plan_row_t plan[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int pixels_sent = 0;
  int writes_checked = 0;
  int frame_ends = 0;
  int settings_count = 0;

  framebuffer_present_format_converter #(
    .DIM_BITS(fpfc_pkg::DIM_BITS_DEFAULT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_source_pixel(in_source_pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_dest_address(out_dest_address),
    .out_dest_pixel(out_dest_pixel),
    .out_frame_last(out_frame_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned usable_dim(logic [fpfc_pkg::DIMR_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  function automatic logic [fpfc_pkg::PIX_W-1:0] repack_pixel(logic [fpfc_pkg::PIX_W-1:0] p,
                                                              fpfc_pkg::layout_t lay);
    logic [4:0] red, blue, tmp;
    logic [5:0] green;
    logic [fpfc_pkg::PIX_W-1:0] q;
    red = p[15:11];
    green = p[10:5];
    blue = p[4:0];
    if (lay.bgr) begin
      tmp = red;
      red = blue;
      blue = tmp;
    end
    // The 555 layouts keep only the upper five bits of green.
    if (lay.is555) q = {1'b0, red, green[5:1], blue};
    else q = {red, green, blue};
    if (lay.swap) q = {q[7:0], q[15:8]};
    return q;
  endfunction

  function automatic logic [fpfc_pkg::CFG_DATA_W-1:0] layout_word(fpfc_pkg::layout_t lay);
    return {{(fpfc_pkg::CFG_DATA_W - fpfc_pkg::LAYOUT_W){1'b0}}, lay};
  endfunction

  // Works out the write caused by one source pixel and moves the scan position on.
  task automatic take_pixel(input logic [fpfc_pkg::PIX_W-1:0] pix, output bit hit,
                            output pixel_write_t w);
    int unsigned sw, sh, srcw, srch, cw, ch, offx, offy;
    longint unsigned dest_row, byte_addr;
    sw = usable_dim(scr_w_q);
    sh = usable_dim(scr_h_q);
    srcw = usable_dim(src_w_q);
    srch = usable_dim(src_h_q);
    cw = (srcw < sw) ? srcw : sw;
    ch = (srch < sh) ? srch : sh;
    offx = (sw - cw) / 2;
    offy = (sh - ch) / 2;
    hit = (col_q < cw) && (row_q < ch);
    w = '0;
    if (hit) begin
      dest_row = offy + ch - 1 - row_q;
      byte_addr = dest_row * pitch_q + (offx + col_q) * 2;
      w.addr = byte_addr[fpfc_pkg::ADDR_W-1:0];
      w.pixel = repack_pixel(pix, layout_q);
      w.last = (col_q == cw - 1) && (row_q == ch - 1);
    end
    // A position left beyond a shrunken source wraps just like a normal row end.
    if (col_q + 1 >= srcw) begin
      col_q = 0;
      row_q = (row_q + 1 >= srch) ? 0 : row_q + 1;
    end else begin
      col_q = col_q + 1;
    end
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [fpfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpfc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      fpfc_pkg::REG_SCREEN_WIDTH: scr_w_q = val[fpfc_pkg::DIMR_W-1:0];
      fpfc_pkg::REG_SCREEN_HEIGHT: scr_h_q = val[fpfc_pkg::DIMR_W-1:0];
      fpfc_pkg::REG_SOURCE_WIDTH: src_w_q = val[fpfc_pkg::DIMR_W-1:0];
      fpfc_pkg::REG_SOURCE_HEIGHT: src_h_q = val[fpfc_pkg::DIMR_W-1:0];
      fpfc_pkg::REG_ROW_PITCH: pitch_q = val[fpfc_pkg::PITCH_W-1:0];
      fpfc_pkg::REG_LAYOUT: layout_q = fpfc_pkg::layout_t'(val[fpfc_pkg::LAYOUT_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stops offering words and waits until every expected write has come out,
  // then waits on so that dropped pixels still in the input stage can drain.
  task automatic settle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A word offered on the input stays put until it is taken.
  task automatic send_pixel(input logic [fpfc_pkg::PIX_W-1:0] pix);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_source_pixel <= pix;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic feed_pixel(input logic [fpfc_pkg::PIX_W-1:0] pix);
    bit hit;
    pixel_write_t w;
    send_pixel(pix);
    take_pixel(pix, hit, w);
    if (hit) pending_writes.push_back(w);
  endtask

  task automatic pick_idling(input int mode);
    case (mode % 4)
      0: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct = 56;
        stall_pct = 0;
      end
      2: begin
        gap_pct = 0;
        stall_pct = 56;
      end
      default: begin
        gap_pct = 24;
        stall_pct = 24;
      end
    endcase
  endtask

  function automatic logic [fpfc_pkg::CFG_DATA_W-1:0] pick_dim(int unsigned roomy_pct);
    if ($urandom_range(0, 99) < roomy_pct)
      return fpfc_pkg::CFG_DATA_W'($urandom_range(0, 32767));
    return fpfc_pkg::CFG_DATA_W'($urandom_range(0, 12));
  endfunction

  function automatic void plan_reg(logic [fpfc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [fpfc_pkg::CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.kind = ROW_REG;
    r.index = idx;
    r.value = val;
    r.pixel = '0;
    r.known = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_pixel(logic [fpfc_pkg::PIX_W-1:0] pix);
    plan_row_t r;
    r.kind = ROW_PIXEL;
    r.index = '0;
    r.value = '0;
    r.pixel = pix;
    r.known = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_known(logic [fpfc_pkg::PIX_W-1:0] pix,
                                     logic [fpfc_pkg::ADDR_W-1:0] addr,
                                     logic [fpfc_pkg::PIX_W-1:0] result, logic last);
    plan_row_t r;
    r.kind = ROW_KNOWN;
    r.index = '0;
    r.value = '0;
    r.pixel = pix;
    r.known.addr = addr;
    r.known.pixel = result;
    r.known.last = last;
    plan.push_back(r);
  endfunction

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached with %0d writes outstanding",
               CYCLE_LIMIT, pending_writes.size());
      $display("framebuffer_present_format_converter regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : check_writes
    pixel_write_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        note_mismatch($sformatf("unexpected write to %0h", out_dest_address));
      end else begin
        want = pending_writes.pop_front();
        if (out_dest_address !== want.addr)
          note_mismatch($sformatf("address %0h, wanted %0h", out_dest_address, want.addr));
        if (out_dest_pixel !== want.pixel)
          note_mismatch($sformatf("pixel %04h, wanted %04h", out_dest_pixel, want.pixel));
        if (out_frame_last !== want.last)
          note_mismatch($sformatf("frame_last %b, wanted %b", out_frame_last, want.last));
        writes_checked++;
        if (want.last) frame_ends++;
      end
    end
  end

  initial begin : run
    bit hit;
    pixel_write_t w;
    plan_row_t row;
    scr_w_q = fpfc_pkg::SCREEN_WIDTH_RST;
    scr_h_q = fpfc_pkg::SCREEN_HEIGHT_RST;
    src_w_q = fpfc_pkg::SOURCE_WIDTH_RST;
    src_h_q = fpfc_pkg::SOURCE_HEIGHT_RST;
    pitch_q = fpfc_pkg::ROW_PITCH_RST;
    layout_q = fpfc_pkg::LAYOUT_RST;
    col_q = 0;
    row_q = 0;

    // Reset geometry: 320x256 on 320x256, pitch 640, so row 0 lands on screen row 255.
    plan_known(16'h0000, 27'd163200, 16'h0000, 1'b0);
    plan_known(16'hFFFF, 27'd163202, 16'hFFFF, 1'b0);
    plan_known(16'hF800, 27'd163204, 16'hF800, 1'b0);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_RGB565_SWAP));
    plan_known(16'h1234, 27'd163206, 16'h3412, 1'b0);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_BGR565));
    plan_known(16'hF800, 27'd163208, 16'h001F, 1'b0);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_BGR565_SWAP));
    plan_known(16'h07FF, 27'd163210, 16'hE0FF, 1'b0);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_RGB555));
    plan_known(16'hFFFF, 27'd163212, 16'h7FFF, 1'b0);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_RGB555_SWAP));
    plan_known(16'h07E0, 27'd163214, 16'hE003, 1'b0);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_BGR555));
    plan_known(16'hF800, 27'd163216, 16'h001F, 1'b0);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_BGR555_SWAP));
    plan_known(16'h001F, 27'd163218, 16'h007C, 1'b0);
    // Zero sizes clamp to one pixel; the column left at ten lies beyond it and wraps.
    plan_reg(fpfc_pkg::REG_SCREEN_WIDTH, 15'd0);
    plan_reg(fpfc_pkg::REG_SCREEN_HEIGHT, 15'd0);
    plan_reg(fpfc_pkg::REG_SOURCE_WIDTH, 15'd0);
    plan_reg(fpfc_pkg::REG_SOURCE_HEIGHT, 15'd0);
    plan_reg(fpfc_pkg::REG_ROW_PITCH, 15'd0);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_RGB565));
    plan_pixel(16'h5555);
    plan_known(16'hABCD, 27'd0, 16'hABCD, 1'b1);
    plan_known(16'h0001, 27'd0, 16'h0001, 1'b1);
    // Oversized screen clamps to 4096 and centers a 3x2 source; pitch of one.
    plan_reg(fpfc_pkg::REG_SCREEN_WIDTH, 15'h7FFF);
    plan_reg(fpfc_pkg::REG_SCREEN_HEIGHT, 15'd8191);
    plan_reg(fpfc_pkg::REG_SOURCE_WIDTH, 15'd3);
    plan_reg(fpfc_pkg::REG_SOURCE_HEIGHT, 15'd2);
    plan_reg(fpfc_pkg::REG_ROW_PITCH, 15'd1);
    plan_pixel(16'h8000);
    plan_pixel(16'h4000);
    plan_pixel(16'h0001);
    plan_pixel(16'h7FFF);
    plan_pixel(16'hAAAA);
    plan_pixel(16'h5555);
    // Source larger than the screen: the pixels outside the 2x1 area give nothing.
    plan_reg(fpfc_pkg::REG_SCREEN_WIDTH, 15'd2);
    plan_reg(fpfc_pkg::REG_SCREEN_HEIGHT, 15'd1);
    plan_reg(fpfc_pkg::REG_SOURCE_WIDTH, 15'd4);
    plan_reg(fpfc_pkg::REG_SOURCE_HEIGHT, 15'd2);
    plan_reg(fpfc_pkg::REG_ROW_PITCH, 15'd32767);
    plan_reg(fpfc_pkg::REG_LAYOUT, layout_word(fpfc_pkg::LAYOUT_RGB555));
    plan_pixel(16'h0841);
    plan_pixel(16'hFFFF);
    plan_pixel(16'h1357);
    plan_pixel(16'hFDB9);

    pick_idling(3);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.index, row.value);
      end else begin
        send_pixel(row.pixel);
        take_pixel(row.pixel, hit, w);
        if (row.kind == ROW_KNOWN) pending_writes.push_back(row.known);
        else if (hit) pending_writes.push_back(w);
      end
    end
    settings_count = 5;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      pick_idling(phase);
      if (phase == 0) begin
        // Largest geometry, so the address reaches its top bits.
        write_reg(fpfc_pkg::REG_SCREEN_WIDTH, 15'd4096);
        write_reg(fpfc_pkg::REG_SCREEN_HEIGHT, 15'd4096);
        write_reg(fpfc_pkg::REG_SOURCE_WIDTH, 15'd4096);
        write_reg(fpfc_pkg::REG_SOURCE_HEIGHT, 15'd4096);
        write_reg(fpfc_pkg::REG_ROW_PITCH, 15'd32767);
      end else if (phase == 1) begin
        write_reg(fpfc_pkg::REG_SCREEN_WIDTH, 15'd1);
        write_reg(fpfc_pkg::REG_SCREEN_HEIGHT, 15'd1);
        write_reg(fpfc_pkg::REG_SOURCE_WIDTH, 15'd1);
        write_reg(fpfc_pkg::REG_SOURCE_HEIGHT, 15'd1);
        write_reg(fpfc_pkg::REG_ROW_PITCH, 15'd2);
      end else begin
        write_reg(fpfc_pkg::REG_SCREEN_WIDTH, pick_dim(30));
        write_reg(fpfc_pkg::REG_SCREEN_HEIGHT, pick_dim(30));
        write_reg(fpfc_pkg::REG_SOURCE_WIDTH, pick_dim(15));
        write_reg(fpfc_pkg::REG_SOURCE_HEIGHT, pick_dim(15));
        case ($urandom_range(0, 3))
          0: write_reg(fpfc_pkg::REG_ROW_PITCH,
                       fpfc_pkg::CFG_DATA_W'($urandom_range(0, 3)));
          1: write_reg(fpfc_pkg::REG_ROW_PITCH,
                       fpfc_pkg::CFG_DATA_W'($urandom_range(32760, 32767)));
          default: write_reg(fpfc_pkg::REG_ROW_PITCH,
                             fpfc_pkg::CFG_DATA_W'($urandom_range(0, 32767)));
        endcase
      end
      write_reg(fpfc_pkg::REG_LAYOUT, fpfc_pkg::CFG_DATA_W'($urandom_range(0, 7)));
      settings_count++;
      for (int n = 0; n < PHASE_PIXELS; n++)
        feed_pixel(fpfc_pkg::PIX_W'($urandom_range(0, 65535)));
    end

    settle();
    $display("covered %0d pixels over %0d register settings, all eight layouts, clamped sizes",
             pixels_sent, settings_count);
    $display("checked %0d writes including %0d frame ends, %0d mismatches",
             writes_checked, frame_ends, mismatch_count);
    if (mismatch_count == 0) begin
      $display("framebuffer_present_format_converter regression: pass");
    end else begin
      $display("framebuffer_present_format_converter regression: fail");
    end
    $finish;
  end

endmodule
